FILE: design/mcrc_pkg.sv
`default_nettype none

package mcrc_pkg;

  // Fixed sizes of the sample path and the counters
  localparam int SAMPLE_BITS  = 12;
  localparam int COUNTER_BITS = 24;
  localparam int HP_BITS      = SAMPLE_BITS + 16;
  localparam int TH_BITS      = HP_BITS - 1;
  localparam int MULA_BITS    = HP_BITS + 1;
  localparam int MULB_BITS    = 17;
  localparam int PROD_BITS    = MULA_BITS + MULB_BITS + 1;
  localparam int ACC_BITS     = TH_BITS + 16;

  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 3;

  typedef logic [SAMPLE_BITS-1:0]          sample_t;
  typedef logic signed [HP_BITS-1:0]       hp_t;
  typedef logic [TH_BITS-1:0]              th_t;
  typedef logic [COUNTER_BITS-1:0]         cnt_t;
  typedef logic signed [MULA_BITS-1:0]     mula_t;
  typedef logic [MULB_BITS-1:0]            mulb_t;
  typedef logic signed [PROD_BITS-1:0]     prod_t;
  typedef logic [ACC_BITS-1:0]             acc_t;
  typedef logic [CFG_INDEX_BITS-1:0]       cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]        cfg_data_t;

  // Threshold averaging weights (0.99 and 0.01 in Q0.16) and the 0.01 floor in Q.8
  localparam logic [15:0] K_KEEP   = 16'd64881;
  localparam logic [15:0] K_NEW    = 16'd655;
  localparam th_t         TH_FLOOR = th_t'(3);
  localparam th_t         TH_MAX   = {TH_BITS{1'b1}};

  // Register indexes
  localparam cfg_index_t REG_HP_ALPHA    = 3'd0;
  localparam cfg_index_t REG_HYSTERESIS  = 3'd1;
  localparam cfg_index_t REG_INIT_THRESH = 3'd2;
  localparam cfg_index_t REG_MIN_PERIOD  = 3'd3;
  localparam cfg_index_t REG_STALE_MAX   = 3'd4;

  // Register reset values
  localparam logic [15:0] HP_ALPHA_RST    = 16'd62259;
  localparam logic [15:0] HYSTERESIS_RST  = 16'd6554;
  localparam logic [19:0] INIT_THRESH_RST = 20'd256;
  localparam logic [15:0] MIN_PERIOD_RST  = 16'd0;
  localparam logic [23:0] STALE_MAX_RST   = 24'd1000;

  // Controller to datapath commands
  typedef struct packed {
    logic load_x;
    logic mul_hp;
    logic step_hp;
    logic step_new;
    logic step_th;
    logic mul_hys;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic seeded;
    logic out_free;
  } status_t;

  // Counter increment that sticks at all ones
  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == {COUNTER_BITS{1'b1}}) ? v : cnt_t'(v + cnt_t'(1));
  endfunction

  // Threshold loaded on the first sample
  function automatic th_t start_threshold(input logic [19:0] init);
    th_t t;
    t = th_t'(init);
    start_threshold = (t < TH_FLOOR) ? TH_FLOOR : t;
  endfunction

endpackage

`default_nettype wire

FILE: design/mcrc_ctrl.sv
`default_nettype none

module mcrc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            sample_valid,
  output logic                 sample_ready,
  input  wire mcrc_pkg::status_t status,
  output mcrc_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MHP  = 3'd1;
  localparam logic [2:0] S_HP   = 3'd2;
  localparam logic [2:0] S_NEW  = 3'd3;
  localparam logic [2:0] S_TH   = 3'd4;
  localparam logic [2:0] S_HYS  = 3'd5;
  localparam logic [2:0] S_DEC  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign sample_ready = (state == S_IDLE);

  // Sequence one word through the shared multiplier
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.load_x = 1'b1;
          state_next = status.seeded ? S_MHP : S_DEC;
        end
      end
      S_MHP: begin
        cmd.mul_hp = 1'b1;
        state_next = S_HP;
      end
      S_HP: begin
        cmd.step_hp = 1'b1;
        state_next  = S_NEW;
      end
      S_NEW: begin
        cmd.step_new = 1'b1;
        state_next   = S_TH;
      end
      S_TH: begin
        cmd.step_th = 1'b1;
        state_next  = S_HYS;
      end
      S_HYS: begin
        cmd.mul_hys = 1'b1;
        state_next  = S_DEC;
      end
      S_DEC: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/mcrc_dp.sv
`default_nettype none

module mcrc_dp (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire mcrc_pkg::cmd_t         cmd,
  output mcrc_pkg::status_t           status,
  input  wire mcrc_pkg::sample_t      sample,
  input  wire logic [15:0]            hp_alpha,
  input  wire logic [15:0]            hysteresis_fraction,
  input  wire logic [19:0]            initial_threshold,
  input  wire logic [15:0]            min_gap,
  input  wire logic [23:0]            stale_max,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output logic                        edge_res,
  output logic [31:0]                 ripple_count,
  output logic [23:0]                 last_period,
  output logic                        no_speed
);

  localparam mcrc_pkg::prod_t HpMaxP =
    mcrc_pkg::prod_t'({1'b0, {(mcrc_pkg::HP_BITS-1){1'b1}}});
  localparam mcrc_pkg::prod_t HpMinP = -HpMaxP - mcrc_pkg::prod_t'(1);
  localparam mcrc_pkg::prod_t RoundP = mcrc_pkg::prod_t'(32768);

  // Filter and counter state
  logic               seeded;
  mcrc_pkg::sample_t  x;
  mcrc_pkg::sample_t  previous_sample;
  mcrc_pkg::hp_t      highpass_value;
  mcrc_pkg::th_t      threshold;
  logic               above_band;
  mcrc_pkg::cnt_t     samples_since_edge;
  mcrc_pkg::cnt_t     edge_gap;
  mcrc_pkg::cnt_t     stale_count;
  logic [31:0]        edge_count;

  // Work registers
  mcrc_pkg::prod_t    prod;
  mcrc_pkg::acc_t     acc;
  mcrc_pkg::hp_t      hp_new;
  mcrc_pkg::th_t      th_new;

  logic signed [mcrc_pkg::SAMPLE_BITS:0] diff;
  mcrc_pkg::mula_t    hp_sum;
  mcrc_pkg::mula_t    mul_a;
  mcrc_pkg::mulb_t    mul_b;
  mcrc_pkg::prod_t    rounded;
  mcrc_pkg::hp_t      hp_sat;
  logic [mcrc_pkg::HP_BITS-1:0] mag;
  logic [mcrc_pkg::ACC_BITS:0]  th_sum;
  logic [mcrc_pkg::TH_BITS:0]   th_shift;
  mcrc_pkg::th_t      th_clamp;
  mcrc_pkg::prod_t    hp_scaled;
  logic               release_hit;
  logic               rise_hit;
  logic               edge_hit;
  mcrc_pkg::cnt_t     since_base;
  mcrc_pkg::cnt_t     stale_base;
  mcrc_pkg::cnt_t     since_next;
  mcrc_pkg::cnt_t     stale_next;
  mcrc_pkg::cnt_t     period_next;
  logic [31:0]        count_next;

  assign status.seeded   = seeded;
  assign status.out_free = !result_valid || result_ready;

  // Filter input: previous output plus the scaled sample step
  assign diff   = $signed({1'b0, x}) - $signed({1'b0, previous_sample});
  assign hp_sum = mcrc_pkg::mula_t'(highpass_value) + mcrc_pkg::mula_t'($signed({diff, 8'b0}));

  // Absolute value of the new filter output
  assign mag = hp_new[mcrc_pkg::HP_BITS-1] ? mcrc_pkg::HP_BITS'(-hp_new)
                                          : mcrc_pkg::HP_BITS'(hp_new);

  // Select the operands of the shared multiplier
  always_comb begin
    mul_a = hp_sum;
    mul_b = {1'b0, hp_alpha};
    priority if (cmd.step_hp) begin
      mul_a = $signed({2'b0, threshold});
      mul_b = {1'b0, mcrc_pkg::K_KEEP};
    end else if (cmd.step_new) begin
      mul_a = $signed({1'b0, mag});
      mul_b = {1'b0, mcrc_pkg::K_NEW};
    end else if (cmd.mul_hys) begin
      mul_a = $signed({2'b0, th_new});
      mul_b = mcrc_pkg::mulb_t'(17'd65536 - {1'b0, hysteresis_fraction});
    end
  end

  // Round to nearest (ties up) and saturate the filter product
  assign rounded = (prod + RoundP) >>> 16;
  assign hp_sat  = (rounded > HpMaxP) ? mcrc_pkg::hp_t'(HpMaxP) :
                   (rounded < HpMinP) ? mcrc_pkg::hp_t'(HpMinP) :
                   mcrc_pkg::hp_t'(rounded);

  // Truncate, floor and saturate the averaged threshold
  assign th_sum   = {1'b0, acc} + {1'b0, prod[mcrc_pkg::ACC_BITS-1:0]};
  assign th_shift = th_sum[mcrc_pkg::ACC_BITS:16];
  assign th_clamp = (th_shift > {1'b0, mcrc_pkg::TH_MAX})   ? mcrc_pkg::TH_MAX   :
                    (th_shift < {1'b0, mcrc_pkg::TH_FLOOR}) ? mcrc_pkg::TH_FLOOR :
                    th_shift[mcrc_pkg::TH_BITS-1:0];

  // Schmitt trigger decisions
  assign hp_scaled   = mcrc_pkg::prod_t'($signed({hp_new, 16'b0}));
  assign release_hit = hp_scaled < prod;
  assign rise_hit    = (mcrc_pkg::mula_t'(hp_new) > $signed({2'b0, th_new})) &&
                       (samples_since_edge >= mcrc_pkg::cnt_t'(min_gap));
  assign edge_hit    = seeded && !above_band && rise_hit;

  // Counter updates for the committed word
  assign since_base  = edge_hit ? '0 : samples_since_edge;
  assign stale_base  = edge_hit ? '0 : stale_count;
  assign since_next  = mcrc_pkg::sat_inc(since_base);
  assign stale_next  = mcrc_pkg::sat_inc(stale_base);
  assign period_next = edge_hit ? samples_since_edge : edge_gap;
  assign count_next  = edge_count + {31'b0, edge_hit};

  // Shared multiplier with registered product
  always_ff @(posedge clk) begin
    if (cmd.mul_hp || cmd.step_hp || cmd.step_new || cmd.mul_hys) begin
      prod <= mul_a * $signed({1'b0, mul_b});
    end
    if (cmd.load_x) begin
      x <= sample;
    end
    if (cmd.step_hp) begin
      hp_new <= hp_sat;
    end
    if (cmd.step_new) begin
      acc <= prod[mcrc_pkg::ACC_BITS-1:0];
    end
    if (cmd.step_th) begin
      th_new <= th_clamp;
    end
  end

  // Commit filter state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded             <= 1'b0;
      previous_sample    <= '0;
      highpass_value     <= '0;
      threshold          <= mcrc_pkg::start_threshold(mcrc_pkg::INIT_THRESH_RST);
      above_band         <= 1'b0;
      samples_since_edge <= '0;
      edge_gap           <= '0;
      stale_count        <= '0;
      edge_count         <= '0;
    end else if (cmd.commit) begin
      seeded             <= 1'b1;
      previous_sample    <= x;
      samples_since_edge <= since_next;
      stale_count        <= stale_next;
      edge_gap           <= period_next;
      edge_count         <= count_next;
      if (!seeded) begin
        highpass_value <= '0;
        threshold      <= mcrc_pkg::start_threshold(initial_threshold);
      end else begin
        highpass_value <= hp_new;
        threshold      <= th_new;
        if (above_band) begin
          if (release_hit) begin
            above_band <= 1'b0;
          end
        end else if (rise_hit) begin
          above_band <= 1'b1;
        end
      end
    end
  end

  // Output register: take a new word while the previous one drains
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      edge_res     <= edge_hit;
      ripple_count <= count_next;
      last_period  <= period_next[23:0];
      no_speed     <= (period_next == '0) || (stale_next > mcrc_pkg::cnt_t'(stale_max));
    end
  end

endmodule

`default_nettype wire

FILE: design/motor_current_ripple_counter.sv
// The first word after reset only seeds the filter: it goes from accept
// straight to commit. No new sample is accepted until a word commits; each
// other word makes four passes through the single shared multiplier and one
// threshold step before its commit, which waits for a free output register.
// Reset (synchronous, active high) restores the register defaults, clears the
// counters and arms the next sample as the seeding word.
`default_nettype none

module motor_current_ripple_counter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        sample_valid,
  output logic             sample_ready,
  input  wire logic [11:0] sample,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic             edge_res,
  output logic [31:0]      ripple_count,
  output logic [23:0]      last_period,
  output logic             no_speed,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  logic [15:0] hp_alpha;
  logic [15:0] hysteresis_fraction;
  logic [19:0] initial_threshold;
  logic [15:0] min_gap;
  logic [23:0] stale_max;

  mcrc_pkg::cmd_t    cmd;
  mcrc_pkg::status_t status;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      hp_alpha            <= mcrc_pkg::HP_ALPHA_RST;
      hysteresis_fraction <= mcrc_pkg::HYSTERESIS_RST;
      initial_threshold   <= mcrc_pkg::INIT_THRESH_RST;
      min_gap             <= mcrc_pkg::MIN_PERIOD_RST;
      stale_max           <= mcrc_pkg::STALE_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcrc_pkg::REG_HP_ALPHA:    hp_alpha            <= cfg_data[15:0];
        mcrc_pkg::REG_HYSTERESIS:  hysteresis_fraction <= cfg_data[15:0];
        mcrc_pkg::REG_INIT_THRESH: initial_threshold   <= cfg_data[19:0];
        mcrc_pkg::REG_MIN_PERIOD:  min_gap             <= cfg_data[15:0];
        mcrc_pkg::REG_STALE_MAX:   stale_max           <= cfg_data;
        default: ;
      endcase
    end
  end

  mcrc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  mcrc_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .sample              (sample),
    .hp_alpha            (hp_alpha),
    .hysteresis_fraction (hysteresis_fraction),
    .initial_threshold   (initial_threshold),
    .min_gap             (min_gap),
    .stale_max           (stale_max),
    .result_valid        (result_valid),
    .result_ready        (result_ready),
    .edge_res            (edge_res),
    .ripple_count        (ripple_count),
    .last_period         (last_period),
    .no_speed            (no_speed)
  );

  // One word in flight: no accept right after an accept
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> !sample_ready)
    else $error("sample accepted while a word is in flight");

  // Commit only into a free output register
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("commit while output register is full");

  // A committed word shows up at the output
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_valid)
    else $error("committed word not presented");

  // A counted edge always follows at least one earlier sample
  a_edge_period: assert property (@(posedge clk) disable iff (rst)
    (result_valid && edge_res) |-> (last_period != 24'd0))
    else $error("edge reported with zero period");

endmodule

`default_nettype wire
